/* rtl/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define LCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lcd_seq_pkg.sv */
package lcd_seq_pkg;

   localparam int CURSOR_W = 6;
   localparam int SHIFT_W  = 4;
   localparam int MAX_COL  = 16;

   localparam logic [1:0] REQ_INIT   = 2'd0;
   localparam logic [1:0] REQ_CHAR   = 2'd1;
   localparam logic [1:0] REQ_CURSOR = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   localparam logic [7:0] CMD_WAKE     = 8'h30;
   localparam logic [7:0] CMD_NIB_MODE = 8'h20;
   localparam logic [7:0] CMD_FSET_8   = 8'h38;
   localparam logic [7:0] CMD_FSET_4   = 8'h28;
   localparam logic [7:0] CMD_DISP_ON  = 8'h0E;
   localparam logic [7:0] CMD_ENTRY    = 8'h06;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_HOME     = 8'h02;
   localparam logic [7:0] CMD_LINE2    = 8'hC0;
   localparam logic [7:0] CMD_SHIFT_R  = 8'h14;

   localparam logic [1:0] WAKE_LAST = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_code;
      logic [1:0] row;
      logic [4:0] col;
   } lcd_req_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_value;
      logic       last;
   } lcd_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WAKE,
      S_NIB,
      S_FSET,
      S_DISP,
      S_ENTRY,
      S_CLEAR,
      S_HOME,
      S_CHAR,
      S_LINE2,
      S_SHIFT
   } lcd_state_type;

   typedef enum logic [3:0] {
      SEL_WAKE,
      SEL_NIB,
      SEL_FSET,
      SEL_DISP,
      SEL_ENTRY,
      SEL_CLEAR,
      SEL_HOME,
      SEL_CHAR,
      SEL_LINE2,
      SEL_SHIFT
   } lcd_sel_type;

   typedef struct packed {
      logic        take;
      logic        emit;
      lcd_sel_type sel;
      logic        raw;
      logic        phase;
      logic        last;
   } lcd_cmd_type;

   typedef struct packed {
      logic               mode4;
      logic               can_emit;
      logic               wrap;
      logic [SHIFT_W-1:0] shifts;
   } lcd_status_type;

endpackage

/* rtl/lcd_seq_ctrl.sv */
`include "assert_macros.svh"

module lcd_seq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  lcd_seq_pkg::lcd_req_type    req_item,
   output logic                        req_stall,
   input  lcd_seq_pkg::lcd_status_type status,
   output lcd_seq_pkg::lcd_cmd_type    cmd
);

   lcd_seq_pkg::lcd_state_type state_ff, state_in;
   logic                                 phase_ff, phase_in;
   logic [lcd_seq_pkg::SHIFT_W-1:0]      rep_ff, rep_in;
   logic                                 mv_ff, mv_in;
   logic                                 raw;
   logic                                 done;

   assign raw  = (state_ff == lcd_seq_pkg::S_WAKE) || (state_ff == lcd_seq_pkg::S_NIB);
   // a byte is complete after one strobe, or after the low nibble
   assign done = raw || !status.mode4 || phase_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      rep_in   = rep_ff;
      mv_in    = mv_ff;
      if (state_ff == lcd_seq_pkg::S_IDLE) begin
         if (req_valid) begin
            phase_in = 1'b0;
            rep_in   = '0;
            mv_in    = 1'b0;
            unique case (req_item.req_type)
               lcd_seq_pkg::REQ_INIT:  state_in = lcd_seq_pkg::S_WAKE;
               lcd_seq_pkg::REQ_CHAR:  state_in = lcd_seq_pkg::S_CHAR;
               lcd_seq_pkg::REQ_CLEAR: state_in = lcd_seq_pkg::S_CLEAR;
               lcd_seq_pkg::REQ_CURSOR: begin
                  mv_in = 1'b1;
                  if (req_item.row == 2'd1) begin
                     state_in = lcd_seq_pkg::S_HOME;
                  end else if (req_item.row == 2'd2) begin
                     state_in = lcd_seq_pkg::S_LINE2;
                  end
               end
               default: state_in = lcd_seq_pkg::S_IDLE;
            endcase
         end
      end else if (status.can_emit) begin
         if (!done) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            unique case (state_ff)
               lcd_seq_pkg::S_WAKE: begin
                  if (rep_ff == lcd_seq_pkg::SHIFT_W'(lcd_seq_pkg::WAKE_LAST)) begin
                     rep_in   = '0;
                     state_in = status.mode4 ? lcd_seq_pkg::S_NIB : lcd_seq_pkg::S_FSET;
                  end else begin
                     rep_in = rep_ff + 1'b1;
                  end
               end
               lcd_seq_pkg::S_NIB:   state_in = lcd_seq_pkg::S_FSET;
               lcd_seq_pkg::S_FSET:  state_in = lcd_seq_pkg::S_DISP;
               lcd_seq_pkg::S_DISP:  state_in = lcd_seq_pkg::S_ENTRY;
               lcd_seq_pkg::S_ENTRY: state_in = lcd_seq_pkg::S_CLEAR;
               lcd_seq_pkg::S_CLEAR: state_in = lcd_seq_pkg::S_HOME;
               lcd_seq_pkg::S_HOME, lcd_seq_pkg::S_LINE2: begin
                  rep_in   = '0;
                  state_in = (mv_ff && status.shifts != '0) ? lcd_seq_pkg::S_SHIFT
                                                            : lcd_seq_pkg::S_IDLE;
               end
               lcd_seq_pkg::S_CHAR:
                  state_in = status.wrap ? lcd_seq_pkg::S_LINE2 : lcd_seq_pkg::S_IDLE;
               lcd_seq_pkg::S_SHIFT: begin
                  if (lcd_seq_pkg::SHIFT_W'(rep_ff + 1'b1) == status.shifts) begin
                     state_in = lcd_seq_pkg::S_IDLE;
                  end else begin
                     rep_in = rep_ff + 1'b1;
                  end
               end
               default: state_in = lcd_seq_pkg::S_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      req_stall = (state_ff != lcd_seq_pkg::S_IDLE);
      cmd.take  = (state_ff == lcd_seq_pkg::S_IDLE) && req_valid;
      cmd.emit  = (state_ff != lcd_seq_pkg::S_IDLE) && status.can_emit;
      cmd.raw   = raw;
      cmd.phase = phase_ff;
      cmd.last  = done && (state_in == lcd_seq_pkg::S_IDLE);
      unique case (state_ff)
         lcd_seq_pkg::S_WAKE:  cmd.sel = lcd_seq_pkg::SEL_WAKE;
         lcd_seq_pkg::S_NIB:   cmd.sel = lcd_seq_pkg::SEL_NIB;
         lcd_seq_pkg::S_FSET:  cmd.sel = lcd_seq_pkg::SEL_FSET;
         lcd_seq_pkg::S_DISP:  cmd.sel = lcd_seq_pkg::SEL_DISP;
         lcd_seq_pkg::S_ENTRY: cmd.sel = lcd_seq_pkg::SEL_ENTRY;
         lcd_seq_pkg::S_CLEAR: cmd.sel = lcd_seq_pkg::SEL_CLEAR;
         lcd_seq_pkg::S_HOME:  cmd.sel = lcd_seq_pkg::SEL_HOME;
         lcd_seq_pkg::S_CHAR:  cmd.sel = lcd_seq_pkg::SEL_CHAR;
         lcd_seq_pkg::S_LINE2: cmd.sel = lcd_seq_pkg::SEL_LINE2;
         lcd_seq_pkg::S_SHIFT: cmd.sel = lcd_seq_pkg::SEL_SHIFT;
         default:              cmd.sel = lcd_seq_pkg::SEL_HOME;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcd_seq_pkg::S_IDLE;
         phase_ff <= 1'b0;
         rep_ff   <= '0;
         mv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rep_ff   <= rep_in;
         mv_ff    <= mv_in;
      end
   end

   `LCD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == lcd_seq_pkg::S_IDLE, "not idle after reset")
   `LCD_ASSERT(a_last_ends, clock, reset, cmd.emit && cmd.last |=> state_ff == lcd_seq_pkg::S_IDLE, "busy after final strobe")
   `LCD_ASSERT(a_phase_mode, clock, reset, phase_ff |-> status.mode4, "nibble phase on eight-bit bus")
   `LCD_ASSERT(a_wake_count, clock, reset, state_ff == lcd_seq_pkg::S_WAKE |-> rep_ff <= lcd_seq_pkg::SHIFT_W'(lcd_seq_pkg::WAKE_LAST), "wake count overrun")

endmodule

/* rtl/lcd_seq_dp.sv */
module lcd_seq_dp #(
   parameter int LINE_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lcd_seq_pkg::lcd_req_type    req_item,
   input  logic                        csr_valid,
   input  logic                        csr_data,
   output logic                        csr_ready,
   output logic                        rsp_valid,
   output lcd_seq_pkg::lcd_rsp_type    rsp_item,
   input  logic                        rsp_stall,
   input  lcd_seq_pkg::lcd_cmd_type    cmd,
   output lcd_seq_pkg::lcd_status_type status
);

   localparam logic [lcd_seq_pkg::CURSOR_W-1:0] LW = lcd_seq_pkg::CURSOR_W'(LINE_WIDTH);

   logic                                mode_ff;
   logic [lcd_seq_pkg::CURSOR_W-1:0]    cursor_ff, cursor_in;
   logic                                wrap_ff, wrap_in;
   logic [lcd_seq_pkg::SHIFT_W-1:0]     shifts_ff, shifts_in;
   logic [7:0]                          char_ff;
   logic                                rsp_valid_ff;
   lcd_seq_pkg::lcd_rsp_type            rsp_item_ff, rsp_item_in;
   logic [lcd_seq_pkg::CURSOR_W-1:0]    cursor_inc;
   logic [4:0]                          col_sat;
   logic [7:0]                          cmd_byte;

   assign csr_ready = 1'b1;

   assign cursor_inc = cursor_ff + 1'b1;

   always_comb begin
      if (req_item.col == 5'd0) begin
         col_sat = 5'd1;
      end else if (req_item.col > 5'(lcd_seq_pkg::MAX_COL)) begin
         col_sat = 5'(lcd_seq_pkg::MAX_COL);
      end else begin
         col_sat = req_item.col;
      end
   end

   // cursor bookkeeping is done once, when the item is taken
   always_comb begin
      cursor_in = cursor_ff;
      wrap_in   = cursor_inc == LW;
      shifts_in = lcd_seq_pkg::SHIFT_W'(col_sat - 5'd1);
      unique case (req_item.req_type)
         lcd_seq_pkg::REQ_INIT, lcd_seq_pkg::REQ_CLEAR: cursor_in = '0;
         lcd_seq_pkg::REQ_CHAR: cursor_in = cursor_inc;
         lcd_seq_pkg::REQ_CURSOR: begin
            if (req_item.row == 2'd1) begin
               cursor_in = lcd_seq_pkg::CURSOR_W'(col_sat - 5'd1);
            end else if (req_item.row == 2'd2) begin
               cursor_in = lcd_seq_pkg::CURSOR_W'(LW - 1'b1 + lcd_seq_pkg::CURSOR_W'(col_sat));
            end
         end
         default: cursor_in = cursor_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.sel)
         lcd_seq_pkg::SEL_WAKE:  cmd_byte = lcd_seq_pkg::CMD_WAKE;
         lcd_seq_pkg::SEL_NIB:   cmd_byte = lcd_seq_pkg::CMD_NIB_MODE;
         lcd_seq_pkg::SEL_FSET:  cmd_byte = mode_ff ? lcd_seq_pkg::CMD_FSET_4
                                                    : lcd_seq_pkg::CMD_FSET_8;
         lcd_seq_pkg::SEL_DISP:  cmd_byte = lcd_seq_pkg::CMD_DISP_ON;
         lcd_seq_pkg::SEL_ENTRY: cmd_byte = lcd_seq_pkg::CMD_ENTRY;
         lcd_seq_pkg::SEL_CLEAR: cmd_byte = lcd_seq_pkg::CMD_CLEAR;
         lcd_seq_pkg::SEL_HOME:  cmd_byte = lcd_seq_pkg::CMD_HOME;
         lcd_seq_pkg::SEL_CHAR:  cmd_byte = char_ff;
         lcd_seq_pkg::SEL_LINE2: cmd_byte = lcd_seq_pkg::CMD_LINE2;
         lcd_seq_pkg::SEL_SHIFT: cmd_byte = lcd_seq_pkg::CMD_SHIFT_R;
         default:                cmd_byte = lcd_seq_pkg::CMD_HOME;
      endcase
   end

   always_comb begin
      rsp_item_in.reg_select = (cmd.sel == lcd_seq_pkg::SEL_CHAR);
      rsp_item_in.last       = cmd.last;
      if (cmd.raw || !mode_ff) begin
         rsp_item_in.bus_value = cmd_byte;
      end else if (cmd.phase) begin
         rsp_item_in.bus_value = {cmd_byte[3:0], 4'h0};
      end else begin
         rsp_item_in.bus_value = {cmd_byte[7:4], 4'h0};
      end
   end

   always_comb begin
      status.mode4    = mode_ff;
      status.can_emit = !rsp_valid_ff || !rsp_stall;
      status.wrap     = wrap_ff;
      status.shifts   = shifts_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         if (cmd.take) begin
            cursor_ff <= cursor_in;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         wrap_ff   <= wrap_in;
         shifts_ff <= shifts_in;
         char_ff   <= req_item.char_code;
      end
      if (cmd.emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

/* rtl/char_lcd_command_sequencer.sv */
// the request is registered into the sequencer state, and each strobe item into the output register
// throughput: one strobe per cycle while rsp_stall is low; a new request is taken only when the
// sequencer is back in idle, since the state machine steps one strobe at a time through the single
// output register
// reset (synchronous, active high): sequencer idle, output empty, column
// counter zero, eight-bit bus mode
module char_lcd_command_sequencer #(
   parameter int LINE_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request items
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lcd_seq_pkg::lcd_req_type req_item,
   // strobe items toward the lcd bus
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lcd_seq_pkg::lcd_rsp_type rsp_item,
   // bus mode register write
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);

   // controller to datapath: take / emit strobes, byte select, nibble phase
   lcd_seq_pkg::lcd_cmd_type    cmd;
   // datapath to controller: bus mode, output space, line wrap, shift count
   lcd_seq_pkg::lcd_status_type status;

   // state machine walks the command list of each request
   lcd_seq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // request latch, column counter, byte and nibble mux, output register
   lcd_seq_dp #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_WIDTH    = 16;
   // wait before a bus mode write, once every request has drained
   localparam int SETTLE_CYCLES = 12;
   // drain time at the end, longer than one full request
   localparam int TAIL_CYCLES   = 40;
   // far above the slowest run with every stall and every long cursor move
   localparam int CYCLE_LIMIT   = 100000;
   localparam int IDLE_PCT      = 30;

   // one request waiting for the driver; hold_off makes it wait for all strobes
   typedef struct {
      lcd_seq_pkg::lcd_req_type req;
      bit                       hold_off;
   } pending_req_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   lcd_seq_pkg::lcd_req_type req_item  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   lcd_seq_pkg::lcd_rsp_type rsp_item;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic                     csr_data  = 1'b0;

   pending_req_type          pending_reqs[$];
   lcd_seq_pkg::lcd_rsp_type strobe_buf[$];
   lcd_seq_pkg::lcd_rsp_type expected_strobes[$];

   // shadow copy of the block's state
   logic       mode4_model  = 1'b0;
   logic [5:0] column_model = '0;

   bit quiet = 1'b0;
   int items_queued = 0;
   int items_taken  = 0;
   int strobes_seen = 0;
   int errors       = 0;
   int cycles       = 0;
   int mode_writes[2];

   char_lcd_command_sequencer #(
      .LINE_WIDTH(LINE_WIDTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // strobe predictor
   // ------------------------------------------------------------------

   // one strobe exactly as it goes on the pins
   function automatic void add_raw(input logic rs, input logic [7:0] val);
      lcd_seq_pkg::lcd_rsp_type s;
      s.reg_select = rs;
      s.bus_value  = val;
      s.last       = 1'b0;
      strobe_buf.push_back(s);
   endfunction

   // a full byte: one strobe on the eight-bit bus, two nibbles high first otherwise
   function automatic void add_byte(input logic rs, input logic [7:0] val);
      if (mode4_model) begin
         add_raw(rs, {val[7:4], 4'h0});
         add_raw(rs, {val[3:0], 4'h0});
      end else begin
         add_raw(rs, val);
      end
   endfunction

   function automatic void clear_home();
      add_byte(1'b0, lcd_seq_pkg::CMD_CLEAR);
      add_byte(1'b0, lcd_seq_pkg::CMD_HOME);
      column_model = '0;
   endfunction

   // home or line two, then shift right up to the column
   function automatic void move_cursor(input logic [1:0] row, input logic [4:0] col);
      logic [4:0] c;
      c = col;
      // column is clamped into 1..16
      if (c == 5'd0) c = 5'd1;
      if (c > 5'(lcd_seq_pkg::MAX_COL)) c = 5'(lcd_seq_pkg::MAX_COL);
      if (row == 2'd1) begin
         column_model = 6'(c - 5'd1);
         add_byte(1'b0, lcd_seq_pkg::CMD_HOME);
      end else if (row == 2'd2) begin
         column_model = 6'(LINE_WIDTH - 1 + c);
         add_byte(1'b0, lcd_seq_pkg::CMD_LINE2);
      end else begin
         // bad row: nothing on the bus, column untouched
         return;
      end
      for (int i = 1; i < c; i++) add_byte(1'b0, lcd_seq_pkg::CMD_SHIFT_R);
   endfunction

   // expand one accepted request into its strobes
   function automatic void predict_strobes(input lcd_seq_pkg::lcd_req_type r);
      strobe_buf.delete();
      case (r.req_type)
         lcd_seq_pkg::REQ_INIT: begin
            add_raw(1'b0, lcd_seq_pkg::CMD_WAKE);
            add_raw(1'b0, lcd_seq_pkg::CMD_WAKE);
            add_raw(1'b0, lcd_seq_pkg::CMD_WAKE);
            if (mode4_model) begin
               add_raw(1'b0, lcd_seq_pkg::CMD_NIB_MODE);
               add_byte(1'b0, lcd_seq_pkg::CMD_FSET_4);
            end else begin
               add_byte(1'b0, lcd_seq_pkg::CMD_FSET_8);
            end
            add_byte(1'b0, lcd_seq_pkg::CMD_DISP_ON);
            add_byte(1'b0, lcd_seq_pkg::CMD_ENTRY);
            clear_home();
         end
         lcd_seq_pkg::REQ_CHAR: begin
            add_byte(1'b1, r.char_code);
            column_model = column_model + 6'd1;
            // end of line one: jump to line two
            if (column_model == 6'(LINE_WIDTH)) move_cursor(2'd2, 5'd1);
         end
         lcd_seq_pkg::REQ_CURSOR: begin
            move_cursor(r.row, r.col);
         end
         default: begin
            clear_home();
         end
      endcase
      if (strobe_buf.size() != 0) strobe_buf[strobe_buf.size() - 1].last = 1'b1;
      foreach (strobe_buf[i]) expected_strobes.push_back(strobe_buf[i]);
   endfunction

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------

   function automatic bit idle_now();
      return !quiet && ($urandom_range(99) < IDLE_PCT);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // item taken at this edge: predict its strobes
         if (req_valid && !req_stall) begin
            predict_strobes(req_item);
            items_taken++;
         end
         // slot is free when nothing was offered or the offer just went through
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && !idle_now() &&
                !(pending_reqs[0].hold_off && expected_strobes.size() != 0)) begin
               req_item  <= pending_reqs[0].req;
               req_valid <= 1'b1;
               pending_reqs.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // strobe monitor
   // ------------------------------------------------------------------

   task automatic check_strobe(input lcd_seq_pkg::lcd_rsp_type got);
      lcd_seq_pkg::lcd_rsp_type want;
      if (expected_strobes.size() == 0) begin
         $display("%0t: strobe with nothing expected, expected none, %s rs=%0b value=%02h last=%0b",
                  $time, "actual", got.reg_select, got.bus_value, got.last);
         errors++;
         return;
      end
      want = expected_strobes.pop_front();
      strobes_seen++;
      if (got.reg_select !== want.reg_select) begin
         $display("%0t: reg_select expected %0b actual %0b", $time, want.reg_select,
                  got.reg_select);
         errors++;
      end
      if (got.bus_value !== want.bus_value) begin
         $display("%0t: bus_value expected %02h actual %02h", $time, want.bus_value,
                  got.bus_value);
         errors++;
      end
      if (got.last !== want.last) begin
         $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_strobe(rsp_item);
         rsp_stall <= idle_now();
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d strobes outstanding", $time,
                  expected_strobes.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   function automatic lcd_seq_pkg::lcd_req_type make_req(input logic [1:0] kind,
                                                         input logic [7:0] ch,
                                                         input logic [1:0] row,
                                                         input logic [4:0] col);
      lcd_seq_pkg::lcd_req_type r;
      r.req_type  = kind;
      r.char_code = ch;
      r.row       = row;
      r.col       = col;
      return r;
   endfunction

   task automatic queue_req(input lcd_seq_pkg::lcd_req_type r, input bit hold_off);
      pending_req_type p;
      p.req      = r;
      p.hold_off = hold_off;
      pending_reqs.push_back(p);
      items_queued++;
   endtask

   // a character item with random filler in the unused fields
   function automatic lcd_seq_pkg::lcd_req_type random_char();
      return make_req(lcd_seq_pkg::REQ_CHAR, 8'($urandom_range(255)),
                      2'($urandom_range(3)), 5'($urandom_range(31)));
   endfunction

   // mostly well-formed text and cursor moves, some clears, inits, broken cursors and noise
   task automatic queue_random(input int budget, input bit long_run);
      int made;
      int pick;
      int len;
      lcd_seq_pkg::lcd_req_type r;
      made = 0;
      if (long_run) begin
         // from column 31 enough text to wrap the counter and hit line two again
         queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'h00, 2'd2, 5'd16), 1'b0);
         for (int i = 0; i < 50; i++) queue_req(random_char(), 1'b0);
         made = 51;
      end
      while (made < budget + (long_run ? 51 : 0)) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) queue_req(random_char(), 1'b0);
            made += len;
            continue;
         end
         r = make_req(lcd_seq_pkg::REQ_CURSOR, 8'($urandom_range(255)),
                      2'($urandom_range(1, 2)), 5'($urandom_range(1, lcd_seq_pkg::MAX_COL)));
         if (pick >= 70 && pick < 78) begin
            // broken cursor: bad row or column outside 1..16
            if ($urandom_range(1)) r.row = $urandom_range(1) ? 2'd3 : 2'd0;
            else r.col = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
         end else if (pick >= 78 && pick < 88) begin
            r.req_type = lcd_seq_pkg::REQ_CLEAR;
         end else if (pick >= 88 && pick < 94) begin
            r.req_type = lcd_seq_pkg::REQ_INIT;
         end else if (pick >= 94) begin
            r = make_req(2'($urandom_range(3)), 8'($urandom_range(255)),
                         2'($urandom_range(3)), 5'($urandom_range(31)));
         end
         // now and then hold the sender until the bus has drained
         queue_req(r, $urandom_range(19) == 0);
         made++;
      end
   endtask

   task automatic wait_idle();
      while (items_taken != items_queued || expected_strobes.size() != 0) @(posedge clock);
   endtask

   // bus mode changes only with the sequencer idle
   task automatic write_bus_mode(input logic mode);
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_data  <= mode;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode4_model = mode;
      mode_writes[int'(mode)]++;
   endtask

   initial begin
      mode_writes[0] = 0;
      mode_writes[1] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // eight-bit bus, directed
      write_bus_mode(1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_INIT,   8'h00, 2'd0, 5'd0),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CHAR,   8'h00, 2'd0, 5'd0),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CHAR,   8'hFF, 2'd3, 5'd31), 1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'h00, 2'd1, 5'd1),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'hFF, 2'd2, 5'd16), 1'b0);
      // rows outside 1..2 put nothing on the bus
      queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'h00, 2'd0, 5'd5),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'h00, 2'd3, 5'd9),  1'b0);
      // columns clamped at both ends
      queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'h00, 2'd1, 5'd0),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'h00, 2'd2, 5'd31), 1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'h00, 2'd1, 5'd17), 1'b0);
      // second character fills line one and jumps to line two
      queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'h00, 2'd1, 5'd15), 1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CHAR,   8'hA5, 2'd0, 5'd0),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CHAR,   8'h5A, 2'd0, 5'd0),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CLEAR,  8'h00, 2'd0, 5'd0),  1'b0);

      // four-bit bus, directed
      write_bus_mode(1'b1);
      queue_req(make_req(lcd_seq_pkg::REQ_INIT,   8'h00, 2'd0, 5'd0),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CHAR,   8'hFF, 2'd0, 5'd0),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CHAR,   8'h00, 2'd0, 5'd0),  1'b0);
      // longest request: line two plus fifteen shifts as nibbles
      queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'h00, 2'd2, 5'd16), 1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CURSOR, 8'h00, 2'd1, 5'd15), 1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CHAR,   8'h3C, 2'd0, 5'd0),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CHAR,   8'hC3, 2'd0, 5'd0),  1'b0);
      queue_req(make_req(lcd_seq_pkg::REQ_CLEAR,  8'h00, 2'd0, 5'd0),  1'b0);

      // random phases, the eight-bit one with no idling on either side
      write_bus_mode(1'b1);
      queue_random(8, 1'b1);
      write_bus_mode(1'b0);
      quiet = 1'b1;
      queue_random(18, 1'b0);
      wait_idle();
      quiet = 1'b0;
      write_bus_mode(1'b1);
      queue_random(12, 1'b0);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_strobes.size() != 0) begin
         $display("%0t: %0d strobes never arrived", $time, expected_strobes.size());
         errors++;
      end
      $display("covered %0d requests and %0d strobes in both bus modes", items_taken,
               strobes_seen);
      $display("bus mode writes: %0d eight-bit, %0d four-bit, %0d mismatches",
               mode_writes[0], mode_writes[1], errors);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

/* char_lcd_command_sequencer.f */
+incdir+rtl
rtl/lcd_seq_pkg.sv
rtl/lcd_seq_ctrl.sv
rtl/lcd_seq_dp.sv
rtl/char_lcd_command_sequencer.sv
verif/testbench.sv
